FILE: rtl/vod_pkg.sv
// ----------------------------------------------------------------------------
// vod_pkg: shared types and decode tables for the VM opcode flow decoder
// Form codes, target kinds and the opcode-to-form decode function.
// ----------------------------------------------------------------------------
package vod_pkg;

	typedef logic [5:0] form_t;
	typedef logic [2:0] kind_t;

	localparam form_t F_NOP   = 6'd0;
	localparam form_t F_CLS   = 6'd1;
	localparam form_t F_RET   = 6'd2;
	localparam form_t F_JP    = 6'd3;
	localparam form_t F_CALL  = 6'd4;
	localparam form_t F_SEI   = 6'd5;
	localparam form_t F_SNEI  = 6'd6;
	localparam form_t F_SER   = 6'd7;
	localparam form_t F_LDB   = 6'd8;
	localparam form_t F_ADDB  = 6'd9;
	localparam form_t F_LDR   = 6'd10;
	localparam form_t F_OR    = 6'd11;
	localparam form_t F_AND   = 6'd12;
	localparam form_t F_XOR   = 6'd13;
	localparam form_t F_ADDR  = 6'd14;
	localparam form_t F_SUB   = 6'd15;
	localparam form_t F_SHR   = 6'd16;
	localparam form_t F_SUBN  = 6'd17;
	localparam form_t F_SHL   = 6'd18;
	localparam form_t F_SNER  = 6'd19;
	localparam form_t F_LDI   = 6'd20;
	localparam form_t F_JPV0  = 6'd21;
	localparam form_t F_RND   = 6'd22;
	localparam form_t F_DRW   = 6'd23;
	localparam form_t F_SKP   = 6'd24;
	localparam form_t F_SKNP  = 6'd25;
	localparam form_t F_LDVDT = 6'd26;
	localparam form_t F_LDK   = 6'd27;
	localparam form_t F_LDDT  = 6'd28;
	localparam form_t F_LDST  = 6'd29;
	localparam form_t F_ADDI  = 6'd30;
	localparam form_t F_LDF   = 6'd31;
	localparam form_t F_LDBCD = 6'd32;
	localparam form_t F_STORE = 6'd33;
	localparam form_t F_LOAD  = 6'd34;

	localparam kind_t K_NONE    = 3'd0;
	localparam kind_t K_JUMP    = 3'd1;
	localparam kind_t K_SUB     = 3'd2;
	localparam kind_t K_INDEX   = 3'd3;
	localparam kind_t K_INDEXED = 3'd4;

	localparam logic [11:0] SYS_CLS = 12'h0E0;
	localparam logic [11:0] SYS_RET = 12'h0EE;
	localparam logic [7:0]  KEY_SKP  = 8'h9E;
	localparam logic [7:0]  KEY_SKNP = 8'hA1;

	typedef struct packed {
		logic skip;
		logic ret;
		logic call;
		logic jump;
	} flow_t;

	function automatic form_t math_form(input logic [3:0] low4);
		form_t f;
		unique case (low4)
			4'h0:    f = F_LDR;
			4'h1:    f = F_OR;
			4'h2:    f = F_AND;
			4'h3:    f = F_XOR;
			4'h4:    f = F_ADDR;
			4'h5:    f = F_SUB;
			4'h6:    f = F_SHR;
			4'h7:    f = F_SUBN;
			4'hE:    f = F_SHL;
			default: f = F_NOP;
		endcase
		return f;
	endfunction

	function automatic form_t misc_form(input logic [7:0] low8);
		form_t f;
		unique case (low8)
			8'h07:   f = F_LDVDT;
			8'h0A:   f = F_LDK;
			8'h15:   f = F_LDDT;
			8'h18:   f = F_LDST;
			8'h1E:   f = F_ADDI;
			8'h29:   f = F_LDF;
			8'h33:   f = F_LDBCD;
			8'h55:   f = F_STORE;
			8'h65:   f = F_LOAD;
			default: f = F_NOP;
		endcase
		return f;
	endfunction

	function automatic form_t decode_form(input logic [15:0] op);
		form_t f;
		unique case (op[15:12])
			4'h0: begin
				if (op[11:0] == SYS_CLS) begin
					f = F_CLS;
				end else if (op[11:0] == SYS_RET) begin
					f = F_RET;
				end else begin
					f = F_NOP;
				end
			end
			4'h1: f = F_JP;
			4'h2: f = F_CALL;
			4'h3: f = F_SEI;
			4'h4: f = F_SNEI;
			4'h5: f = (op[3:0] == 4'h0) ? F_SER : F_NOP;
			4'h6: f = F_LDB;
			4'h7: f = F_ADDB;
			4'h8: f = math_form(op[3:0]);
			4'h9: f = F_SNER;
			4'hA: f = F_LDI;
			4'hB: f = F_JPV0;
			4'hC: f = F_RND;
			4'hD: f = F_DRW;
			4'hE: begin
				if (op[7:0] == KEY_SKP) begin
					f = F_SKP;
				end else if (op[7:0] == KEY_SKNP) begin
					f = F_SKNP;
				end else begin
					f = F_NOP;
				end
			end
			default: f = misc_form(op[7:0]);
		endcase
		return f;
	endfunction

endpackage

FILE: rtl/vm_opcode_flow_decoder.sv
// ----------------------------------------------------------------------------
// vm_opcode_flow_decoder: opcode form, operand and control-flow decoder
// Decodes one 16-bit VM opcode and its fetch address into a form code,
// operand fields, target address and successor addresses.
// ----------------------------------------------------------------------------
//  channel | signals                         | role
//  --------+---------------------------------+-----------------------------
//  in      | in_valid/in_ready, 2 fields     | fetch address and opcode beat
//  out     | out_valid/out_ready, 10 fields  | decoded beat, one per input
//
//  Three register stages: form decode, adders and kind, successor select.
//  One beat enters and one leaves every cycle while out_ready is high.
//  Each stage holds while the stage after it is full and stalled; empty
//  stages fill behind a stalled one, so a bubble never blocks input.
//  Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module vm_opcode_flow_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] instr_address,
	input  logic [15:0] opcode_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  instruction_form,
	output logic [3:0]  reg_x_index,
	output logic [3:0]  reg_y_index,
	output logic [7:0]  imm_byte,
	output logic [3:0]  low_nibble,
	output logic [11:0] target_address,
	output logic [1:0]  successor_count,
	output logic [15:0] first_successor,
	output logic [15:0] second_successor,
	output logic [2:0]  target_kind
);

	logic adv1, adv2, adv3;

	logic                valid_s1;
	logic [15:0]         addr_s1;
	logic [15:0]         op_s1;
	vod_pkg::form_t      form_s1;

	logic                valid_s2;
	logic [15:0]         op_s2;
	vod_pkg::form_t      form_s2;
	vod_pkg::kind_t      kind_s2;
	vod_pkg::flow_t      flow_s2;
	logic [15:0]         next_s2;
	logic [15:0]         after_s2;

	logic                valid_s3;
	logic [15:0]         op_s3;
	vod_pkg::form_t      form_s3;
	vod_pkg::kind_t      kind_s3;
	logic [11:0]         target_s3;
	logic [1:0]          count_s3;
	logic [15:0]         first_s3;
	logic [15:0]         second_s3;

	vod_pkg::kind_t      kind_d;
	vod_pkg::flow_t      flow_d;
	logic [11:0]         target_d;
	logic [1:0]          count_d;
	logic [15:0]         first_d;
	logic [15:0]         second_d;

	assign adv3     = !valid_s3 || out_ready;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		kind_d = vod_pkg::K_NONE;
		flow_d = '0;
		unique case (form_s1) inside
			vod_pkg::F_JP: begin
				kind_d      = vod_pkg::K_JUMP;
				flow_d.jump = 1'b1;
			end
			vod_pkg::F_CALL: begin
				kind_d      = vod_pkg::K_SUB;
				flow_d.call = 1'b1;
			end
			vod_pkg::F_LDI: kind_d = vod_pkg::K_INDEX;
			vod_pkg::F_JPV0: begin
				kind_d      = vod_pkg::K_INDEXED;
				flow_d.jump = 1'b1;
			end
			vod_pkg::F_RET: flow_d.ret = 1'b1;
			vod_pkg::F_SEI, vod_pkg::F_SNEI, vod_pkg::F_SER, vod_pkg::F_SNER,
			vod_pkg::F_SKP, vod_pkg::F_SKNP: flow_d.skip = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		target_d = (kind_s2 != vod_pkg::K_NONE) ? op_s2[11:0] : 12'd0;
		count_d  = 2'd1;
		first_d  = next_s2;
		second_d = 16'd0;
		if (flow_s2.ret) begin
			count_d = 2'd0;
			first_d = 16'd0;
		end else if (flow_s2.jump) begin
			first_d = {4'd0, op_s2[11:0]};
		end else if (flow_s2.call) begin
			count_d  = 2'd2;
			second_d = {4'd0, op_s2[11:0]};
		end else if (flow_s2.skip) begin
			count_d  = 2'd2;
			second_d = after_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			addr_s1 <= instr_address;
			op_s1   <= opcode_word;
			form_s1 <= vod_pkg::decode_form(opcode_word);
		end
		if (adv2 && valid_s1) begin
			op_s2    <= op_s1;
			form_s2  <= form_s1;
			kind_s2  <= kind_d;
			flow_s2  <= flow_d;
			next_s2  <= addr_s1 + 16'd2;
			after_s2 <= addr_s1 + 16'd4;
		end
		if (adv3 && valid_s2) begin
			op_s3     <= op_s2;
			form_s3   <= form_s2;
			kind_s3   <= kind_s2;
			target_s3 <= target_d;
			count_s3  <= count_d;
			first_s3  <= first_d;
			second_s3 <= second_d;
		end
	end

	assign out_valid        = valid_s3;
	assign instruction_form = form_s3;
	assign reg_x_index      = op_s3[11:8];
	assign reg_y_index      = op_s3[7:4];
	assign imm_byte         = op_s3[7:0];
	assign low_nibble       = op_s3[3:0];
	assign target_address   = target_s3;
	assign successor_count  = count_s3;
	assign first_successor  = first_s3;
	assign second_successor = second_s3;
	assign target_kind      = kind_s3;

`ifndef SYNTHESIS
	a_ret_no_succ: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (count_s3 == 2'd0) |-> (form_s3 == vod_pkg::F_RET) && (first_s3 == 16'd0))
		else $error("zero successors on a non-return beat");

	a_jump_first: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (kind_s3 == vod_pkg::K_JUMP) |-> (first_s3 == {4'd0, target_s3}))
		else $error("jump beat first successor differs from target");

	a_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (kind_s3 == vod_pkg::K_NONE) |-> (target_s3 == 12'd0))
		else $error("target address set without a target kind");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv2 |=> valid_s1 && $stable(op_s1) && $stable(addr_s1))
		else $error("stage 1 beat lost during stall");

	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv2 |=> valid_s2 && (op_s2 == $past(op_s1)))
		else $error("stage 1 beat not moved into stage 2");
`endif

endmodule
